// ===== rtl/gfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared widths, fixed-point constants and the pipeline control type of the
// gaussian field evaluator.
// ----------------------------------------------------------------------------
package gfe_pkg;

    // coordinate and fixed-point format
    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int AXES            = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int AMP_WIDTH       = 32;
    localparam int RES_WIDTH       = 32;
    localparam int SIGMA_WIDTH     = 31;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PEAK_AMPLITUDE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPREAD_SIGMA   = 3'd4;

    // distance path
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int MAG_WIDTH  = COORD_WIDTH;
    localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH  = SQ_WIDTH + 2;

    // divider: exponent limit is 32.0, so the quotient needs int+frac+1 bits
    localparam int EXP_INT_BITS = 5;
    localparam int DEN_WIDTH    = 2 * SIGMA_WIDTH + 1;
    localparam int DIV_STEPS    = EXP_INT_BITS + FRAC_BITS + 1;
    localparam int QUO_WIDTH    = DIV_STEPS;
    localparam int LOW_BITS     = DIV_STEPS - FRAC_BITS;
    localparam int HEAD_WIDTH   = SUM_WIDTH - LOW_BITS;
    localparam logic [QUO_WIDTH-1:0] EXP_LIMIT =
        QUO_WIDTH'(1) << (EXP_INT_BITS + FRAC_BITS);

    // exponential in Q1.30
    localparam int Q30         = 30;
    localparam int SER_WIDTH   = Q30 + 1;
    localparam int T_WIDTH     = Q30;
    localparam int Y_WIDTH     = QUO_WIDTH + SER_WIDTH - FRAC_BITS;
    localparam int SHIFT_WIDTH = Y_WIDTH - Q30;
    localparam logic [SER_WIDTH-1:0] ONE_Q30   = SER_WIDTH'(1) << Q30;
    localparam logic [SER_WIDTH-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [T_WIDTH-1:0]   LN2_Q30   = 30'd744261118;
    localparam int SERIES_TERMS = 12;

    // reciprocal multiply for division of a Q30 value by a small constant
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_WIDTH = 34;

    // final scaling
    localparam int PROD_WIDTH = AMP_WIDTH + SER_WIDTH;
    localparam logic [PROD_WIDTH:0] ROUND_HALF = (PROD_WIDTH + 1)'(1) << (Q30 - 1);

    // valid bit and forced-zero flag that travel with each transaction
    typedef struct packed {
        logic valid;
        logic zero;
    } gfe_ctl_t;

    // ceil(2^34 / k) for the series divisors 2..12
    function automatic logic [RECIP_WIDTH-1:0] recip_of(input int k);
        logic [RECIP_WIDTH-1:0] m;
        case (k)
            2:       m = 34'd8589934592;
            3:       m = 34'd5726623062;
            4:       m = 34'd4294967296;
            5:       m = 34'd3435973837;
            6:       m = 34'd2863311531;
            7:       m = 34'd2454267027;
            8:       m = 34'd2147483648;
            9:       m = 34'd1908874354;
            10:      m = 34'd1717986919;
            11:      m = 34'd1561806290;
            12:      m = 34'd1431655766;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/gfe_exp_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfe_exp_pipe
// Pipelined exp(-x) for x in Q.16: splits x*log2(e) into integer and
// fraction, runs a 12-term alternating series on the fraction and shifts.
// ----------------------------------------------------------------------------
module gfe_exp_pipe
    import gfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [QUO_WIDTH-1:0] x_in,
    input  gfe_ctl_t             ctl_in,
    output logic [SER_WIDTH-1:0] g_out,
    output gfe_ctl_t             ctl_out
);

    // stage e1: y = x * log2(e)
    logic [QUO_WIDTH+SER_WIDTH-1:0] y_prod;
    logic [Y_WIDTH-1:0]             e1_y_next;
    gfe_ctl_t                       e1_ctl_next;
    logic [Y_WIDTH-1:0]             e1_y_reg;
    gfe_ctl_t                       e1_ctl_reg;

    assign y_prod = (QUO_WIDTH + SER_WIDTH)'(x_in) * (QUO_WIDTH + SER_WIDTH)'(LOG2E_Q30);
    assign e1_y_next = y_prod[FRAC_BITS +: Y_WIDTH];

    // exponent above the limit forces a zero result
    assign e1_ctl_next = '{valid: ctl_in.valid, zero: ctl_in.zero || (x_in > EXP_LIMIT)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_ctl_reg <= '0;
        end
        else if (en)
        begin
            e1_ctl_reg <= e1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_y_reg <= e1_y_next;
        end
    end

    // stage e2: t = frac(y) * ln2, n = int(y)
    logic [2*T_WIDTH-1:0]   t_prod;
    logic [T_WIDTH-1:0]     e2_t_reg;
    logic [SHIFT_WIDTH-1:0] e2_n_reg;
    gfe_ctl_t               e2_ctl_reg;

    assign t_prod = (2 * T_WIDTH)'(e1_y_reg[Q30-1:0]) * (2 * T_WIDTH)'(LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_ctl_reg <= '0;
        end
        else if (en)
        begin
            e2_ctl_reg <= e1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_t_reg <= t_prod[Q30 +: T_WIDTH];
            e2_n_reg <= e1_y_reg[Y_WIDTH-1:Q30];
        end
    end

    // series: per term one multiply stage (a) and one divide stage (b)
    logic [SER_WIDTH-1:0]   sa_sum_reg  [SERIES_TERMS];
    logic [T_WIDTH-1:0]     sa_prod_reg [SERIES_TERMS];
    logic [T_WIDTH-1:0]     sa_t_reg    [SERIES_TERMS];
    logic [SHIFT_WIDTH-1:0] sa_n_reg    [SERIES_TERMS];
    gfe_ctl_t               sa_ctl_reg  [SERIES_TERMS];
    logic [SER_WIDTH-1:0]   sb_sum_reg  [SERIES_TERMS];
    logic [T_WIDTH-1:0]     sb_term_reg [SERIES_TERMS];
    logic [T_WIDTH-1:0]     sb_t_reg    [SERIES_TERMS];
    logic [SHIFT_WIDTH-1:0] sb_n_reg    [SERIES_TERMS];
    gfe_ctl_t               sb_ctl_reg  [SERIES_TERMS];

    for (genvar j = 0; j < SERIES_TERMS; j++)
    begin : g_term
        logic [SER_WIDTH-1:0]   sa_sum_next;
        logic [T_WIDTH-1:0]     sa_prod_next;
        logic [T_WIDTH-1:0]     sa_t_next;
        logic [SHIFT_WIDTH-1:0] sa_n_next;
        gfe_ctl_t               sa_ctl_next;
        logic [T_WIDTH-1:0]     sb_term_next;

        if (j == 0)
        begin : g_first
            // first term is t itself, sum starts at one
            assign sa_sum_next  = ONE_Q30;
            assign sa_prod_next = e2_t_reg;
            assign sa_t_next    = e2_t_reg;
            assign sa_n_next    = e2_n_reg;
            assign sa_ctl_next  = e2_ctl_reg;
            assign sb_term_next = sa_prod_reg[j];
        end
        else
        begin : g_next
            logic [2*T_WIDTH-1:0]           mul;
            logic [T_WIDTH+RECIP_WIDTH-1:0] quo;

            // fold the previous term into the sum, odd terms subtract
            if ((j % 2) == 1)
            begin : g_sub
                assign sa_sum_next = sb_sum_reg[j-1] - SER_WIDTH'(sb_term_reg[j-1]);
            end
            else
            begin : g_add
                assign sa_sum_next = sb_sum_reg[j-1] + SER_WIDTH'(sb_term_reg[j-1]);
            end

            assign mul = (2 * T_WIDTH)'(sb_term_reg[j-1]) * (2 * T_WIDTH)'(sb_t_reg[j-1]);
            assign sa_prod_next = mul[Q30 +: T_WIDTH];
            assign sa_t_next    = sb_t_reg[j-1];
            assign sa_n_next    = sb_n_reg[j-1];
            assign sa_ctl_next  = sb_ctl_reg[j-1];

            // floor division by the term index through its reciprocal
            assign quo = (T_WIDTH + RECIP_WIDTH)'(sa_prod_reg[j])
                       * (T_WIDTH + RECIP_WIDTH)'(recip_of(j + 1));
            assign sb_term_next = quo[RECIP_SHIFT +: T_WIDTH];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sa_ctl_reg[j] <= '0;
                sb_ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                sa_ctl_reg[j] <= sa_ctl_next;
                sb_ctl_reg[j] <= sa_ctl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sa_sum_reg[j]  <= sa_sum_next;
                sa_prod_reg[j] <= sa_prod_next;
                sa_t_reg[j]    <= sa_t_next;
                sa_n_reg[j]    <= sa_n_next;
                sb_sum_reg[j]  <= sa_sum_reg[j];
                sb_term_reg[j] <= sb_term_next;
                sb_t_reg[j]    <= sa_t_reg[j];
                sb_n_reg[j]    <= sa_n_reg[j];
            end
        end
    end

    // stage f1: last term, then scale by 2^-n
    logic [SER_WIDTH-1:0] sum_fin;
    logic [SER_WIDTH-1:0] g_next;
    logic [SER_WIDTH-1:0] g_reg;
    gfe_ctl_t             g_ctl_reg;

    if ((SERIES_TERMS % 2) == 1)
    begin : g_fin_sub
        assign sum_fin = sb_sum_reg[SERIES_TERMS-1] - SER_WIDTH'(sb_term_reg[SERIES_TERMS-1]);
    end
    else
    begin : g_fin_add
        assign sum_fin = sb_sum_reg[SERIES_TERMS-1] + SER_WIDTH'(sb_term_reg[SERIES_TERMS-1]);
    end

    assign g_next = sum_fin >> sb_n_reg[SERIES_TERMS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_ctl_reg <= '0;
        end
        else if (en)
        begin
            g_ctl_reg <= sb_ctl_reg[SERIES_TERMS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= g_next;
        end
    end

    assign g_out   = g_reg;
    assign ctl_out = g_ctl_reg;

endmodule

// ===== rtl/gaussian_field_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_field_evaluator
// pipeline: a transaction passes 56 register stages on its way to field_value
//   (5 distance, 22 restoring divide steps, 27 exponential incl. two stages
//   per series term, 2 scaling)
// throughput: one transaction per cycle; the whole pipeline holds while the
//   output register waits on out_ready
// reset: async active low, clears all valid bits and loads centers 0,
//   amplitude 1.0 and sigma 1.0; no clearing pass
// ----------------------------------------------------------------------------
module gaussian_field_evaluator
    import gfe_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [RES_WIDTH-1:0]       field_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam logic [AMP_WIDTH-1:0]   AMP_RESET   = 32'd65536;
    localparam logic [SIGMA_WIDTH-1:0] SIGMA_RESET = 31'd65536;

    // configuration registers
    logic [COORD_WIDTH-1:0] center_x_reg;
    logic [COORD_WIDTH-1:0] center_y_reg;
    logic [COORD_WIDTH-1:0] center_z_reg;
    logic [AMP_WIDTH-1:0]   amp_reg;
    logic [SIGMA_WIDTH-1:0] sigma_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            amp_reg      <= AMP_RESET;
            sigma_reg    <= SIGMA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:       center_x_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_CENTER_Y:       center_y_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_CENTER_Z:       center_z_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_PEAK_AMPLITUDE: amp_reg      <= cfg_data[AMP_WIDTH-1:0];
                REG_SPREAD_SIGMA:   sigma_reg    <= cfg_data[SIGMA_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // derived configuration: 2*sigma^2 and amplitude sign/magnitude
    logic [DEN_WIDTH-1:0] den_next;
    logic [AMP_WIDTH-1:0] amp_mag_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [AMP_WIDTH-1:0] amp_mag_reg;
    logic                 amp_neg_reg;

    assign den_next = {(2 * SIGMA_WIDTH)'(sigma_reg) * (2 * SIGMA_WIDTH)'(sigma_reg), 1'b0};
    assign amp_mag_next = amp_reg[AMP_WIDTH-1] ? (~amp_reg + AMP_WIDTH'(1)) : amp_reg;

    always_ff @(posedge clk)
    begin
        den_reg     <= den_next;
        amp_mag_reg <= amp_mag_next;
        amp_neg_reg <= amp_reg[AMP_WIDTH-1];
    end

    // global advance: the pipeline moves unless the output register is stuck
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage s1: signed differences
    logic [COORD_WIDTH-1:0] pt [AXES];
    logic [COORD_WIDTH-1:0] ct [AXES];
    logic [DIFF_WIDTH-1:0]  diff_next [AXES];
    logic [DIFF_WIDTH-1:0]  s1_diff_reg [AXES];
    logic                   s1_valid_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign ct[0] = center_x_reg;
    assign ct[1] = center_y_reg;
    assign ct[2] = center_z_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff_next[i] = {pt[i][COORD_WIDTH-1], pt[i]} - {ct[i][COORD_WIDTH-1], ct[i]};
        end
    end

    // stage s2: magnitudes
    logic [MAG_WIDTH-1:0] mag_next [AXES];
    logic [MAG_WIDTH-1:0] s2_mag_reg [AXES];
    logic                 s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag_next[i] = s1_diff_reg[i][DIFF_WIDTH-1] ? MAG_WIDTH'(-s1_diff_reg[i])
                                                       : s1_diff_reg[i][MAG_WIDTH-1:0];
        end
    end

    // stage s3: squares
    logic [SQ_WIDTH-1:0] sq_next [AXES];
    logic [SQ_WIDTH-1:0] s3_sq_reg [AXES];
    logic                s3_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            sq_next[i] = SQ_WIDTH'(s2_mag_reg[i]) * SQ_WIDTH'(s2_mag_reg[i]);
        end
    end

    // stage s4: squared distance
    logic [SUM_WIDTH-1:0] sum_next;
    logic [SUM_WIDTH-1:0] s4_sum_reg;
    logic                 s4_valid_reg;

    assign sum_next = SUM_WIDTH'(s3_sq_reg[0]) + SUM_WIDTH'(s3_sq_reg[1])
                    + SUM_WIDTH'(s3_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_diff_reg <= diff_next;
            s2_mag_reg  <= mag_next;
            s3_sq_reg   <= sq_next;
            s4_sum_reg  <= sum_next;
        end
    end

    // stage s5: quotient >= 2^22 check, divider setup
    // low dividend bits and quotient bits share one shift register
    logic [DEN_WIDTH-1:0] div_rem_reg  [DIV_STEPS+1];
    logic [QUO_WIDTH-1:0] div_bits_reg [DIV_STEPS+1];
    gfe_ctl_t             div_ctl_reg  [DIV_STEPS+1];
    logic [HEAD_WIDTH-1:0] head;
    logic                  ovf;

    assign head = s4_sum_reg[SUM_WIDTH-1:LOW_BITS];
    assign ovf  = DEN_WIDTH'(head) >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            div_ctl_reg[0] <= '{valid: s4_valid_reg, zero: ovf};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_rem_reg[0]  <= DEN_WIDTH'(head);
            div_bits_reg[0] <= {s4_sum_reg[LOW_BITS-1:0], FRAC_BITS'(0)};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [DEN_WIDTH:0]   trial;
        logic [DEN_WIDTH:0]   trial_sub;
        logic                 take;
        logic [DEN_WIDTH-1:0] rem_next;
        logic [QUO_WIDTH-1:0] bits_next;

        assign trial     = {div_rem_reg[i], div_bits_reg[i][QUO_WIDTH-1]};
        assign take      = trial >= {1'b0, den_reg};
        assign trial_sub = trial - {1'b0, den_reg};
        assign rem_next  = take ? trial_sub[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
        assign bits_next = {div_bits_reg[i][QUO_WIDTH-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_ctl_reg[i+1] <= '0;
            end
            else if (en)
            begin
                div_ctl_reg[i+1] <= div_ctl_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_reg[i+1]  <= rem_next;
                div_bits_reg[i+1] <= bits_next;
            end
        end
    end

    // exponential
    logic [SER_WIDTH-1:0] exp_g;
    gfe_ctl_t             exp_ctl;

    gfe_exp_pipe u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .x_in    (div_bits_reg[DIV_STEPS]),
        .ctl_in  (div_ctl_reg[DIV_STEPS]),
        .g_out   (exp_g),
        .ctl_out (exp_ctl)
    );

    // stage p1: |amplitude| * falloff
    logic [PROD_WIDTH-1:0] prod_next;
    logic [PROD_WIDTH-1:0] p1_prod_reg;
    gfe_ctl_t              p1_ctl_reg;

    assign prod_next = PROD_WIDTH'(amp_mag_reg) * PROD_WIDTH'(exp_g);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
        end
        else if (en)
        begin
            p1_ctl_reg <= exp_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_prod_reg <= prod_next;
        end
    end

    // output register: round half away from zero, restore sign, force zero
    logic [PROD_WIDTH:0]  rounded;
    logic [RES_WIDTH-1:0] res_mag;
    logic [RES_WIDTH-1:0] field_value_next;
    logic [RES_WIDTH-1:0] field_value_reg;

    assign rounded = {1'b0, p1_prod_reg} + ROUND_HALF;
    assign res_mag = rounded[Q30 +: RES_WIDTH];

    always_comb
    begin
        if (p1_ctl_reg.zero)
        begin
            field_value_next = '0;
        end
        else if (amp_neg_reg)
        begin
            field_value_next = ~res_mag + RES_WIDTH'(1);
        end
        else
        begin
            field_value_next = res_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p1_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            field_value_reg <= field_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_value = field_value_reg;

    // a flagged transaction leaves as zero
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && p1_ctl_reg.valid && p1_ctl_reg.zero) |=> (out_valid_reg && field_value_reg == '0))
        else $error("flagged transaction did not produce zero");

    // the series result never exceeds one
    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        exp_ctl.valid |-> (exp_g <= ONE_Q30))
        else $error("exponential out of range");

    // output valid only rises from a transaction in the last stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(p1_ctl_reg.valid))
        else $error("output valid without a source transaction");

endmodule
